/* rtl/shd_pkg.sv */
`timescale 1ns / 1ps

package shd_pkg;

	// Sync pair and header geometry
	localparam logic [7:0] SYNC_FIRST  = 8'h03;
	localparam logic [7:0] SYNC_SECOND = 8'h16;
	localparam int         CNT_W       = 5;

	localparam logic [CNT_W-1:0] POS_FIRST_FIELD = 5'd2;
	localparam logic [CNT_W-1:0] POS_SEND        = 5'd4;
	localparam logic [CNT_W-1:0] POS_RECV        = 5'd8;
	localparam logic [CNT_W-1:0] POS_APP         = 5'd12;
	localparam logic [CNT_W-1:0] POS_SERVER      = 5'd16;
	localparam logic [CNT_W-1:0] POS_EVENT       = 5'd20;
	localparam logic [CNT_W-1:0] POS_MSG         = 5'd22;
	localparam logic [CNT_W-1:0] POS_LEN         = 5'd24;
	localparam logic [CNT_W-1:0] POS_LAST        = 5'd27;

	// Result kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// Configuration register indexes
	localparam logic CFG_NODE_ID        = 1'b0;
	localparam logic CFG_MAIN_SERVER_ID = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_SYNC = 2'd1,
		PH_HEAD = 2'd2,
		PH_PAY  = 2'd3
	} phase_t;

	// One result item
	typedef struct packed {
		logic        kind;
		logic [31:0] send_node;
		logic [31:0] recv_node;
		logic [31:0] app_id;
		logic [31:0] server_id;
		logic [15:0] event_id;
		logic [15:0] message_type;
		logic [31:0] payload_length;
		logic        deliver_local;
		logic [7:0]  payload_byte;
		logic        frame_last;
	} result_t;

	// Configuration values seen by the parser
	typedef struct packed {
		logic [31:0] node_id;
		logic [31:0] main_server_id;
	} cfg_t;

endpackage

/* rtl/shd_parser.sv */
`timescale 1ns / 1ps

module shd_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           byte_in,
	input  shd_pkg::cfg_t        cfg,
	output logic                 has_result,
	output shd_pkg::result_t     result
);

	shd_pkg::phase_t               phase_q, phase_d;
	logic [shd_pkg::CNT_W-1:0]     count_q, count_d;
	logic [31:0]                   send_q, recv_q, app_q, srv_q, len_q, rem_q;
	logic [15:0]                   evt_q, msg_q;
	logic [31:0]                   send_d, recv_d, app_d, srv_d, len_d, rem_d;
	logic [15:0]                   evt_d, msg_d;
	logic [31:0]                   rem_dec;
	logic                          local_hit;

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= shd_pkg::PH_HUNT;
			count_q <= '0;
			send_q  <= '0;
			recv_q  <= '0;
			app_q   <= '0;
			srv_q   <= '0;
			evt_q   <= '0;
			msg_q   <= '0;
			len_q   <= '0;
			rem_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			count_q <= count_d;
			send_q  <= send_d;
			recv_q  <= recv_d;
			app_q   <= app_d;
			srv_q   <= srv_d;
			evt_q   <= evt_d;
			msg_q   <= msg_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
		end
	end

	assign rem_dec = (rem_q != 32'd0) ? (rem_q - 32'd1) : 32'd0;

	// Local delivery test on the fully assembled header
	assign local_hit = (srv_d == cfg.main_server_id) &&
		(((recv_d == 32'd0) && (send_d == 32'd0)) || (recv_d == cfg.node_id));

	// Next state and result
	always_comb begin
		phase_d    = phase_q;
		count_d    = count_q;
		send_d     = send_q;
		recv_d     = recv_q;
		app_d      = app_q;
		srv_d      = srv_q;
		evt_d      = evt_q;
		msg_d      = msg_q;
		len_d      = len_q;
		rem_d      = rem_q;
		has_result = 1'b0;
		result     = '0;

		case (phase_q)
			shd_pkg::PH_HUNT: begin
				if (byte_in == shd_pkg::SYNC_FIRST) phase_d = shd_pkg::PH_SYNC;
			end
			shd_pkg::PH_SYNC: begin
				if (byte_in == shd_pkg::SYNC_SECOND) begin
					phase_d = shd_pkg::PH_HEAD;
					count_d = shd_pkg::POS_FIRST_FIELD;
					send_d  = '0;
					recv_d  = '0;
					app_d   = '0;
					srv_d   = '0;
					evt_d   = '0;
					msg_d   = '0;
					len_d   = '0;
				end else if (byte_in != shd_pkg::SYNC_FIRST) begin
					phase_d = shd_pkg::PH_HUNT;
				end
			end
			shd_pkg::PH_HEAD: begin
				// shift the byte into the field that owns this position
				if (count_q >= shd_pkg::POS_LEN)         len_d  = {len_q[23:0], byte_in};
				else if (count_q >= shd_pkg::POS_MSG)    msg_d  = {msg_q[7:0], byte_in};
				else if (count_q >= shd_pkg::POS_EVENT)  evt_d  = {evt_q[7:0], byte_in};
				else if (count_q >= shd_pkg::POS_SERVER) srv_d  = {srv_q[23:0], byte_in};
				else if (count_q >= shd_pkg::POS_APP)    app_d  = {app_q[23:0], byte_in};
				else if (count_q >= shd_pkg::POS_RECV)   recv_d = {recv_q[23:0], byte_in};
				else if (count_q >= shd_pkg::POS_SEND)   send_d = {send_q[23:0], byte_in};

				if (count_q != shd_pkg::POS_LAST) begin
					count_d = count_q + 5'd1;
				end else begin
					count_d                = '0;
					has_result             = 1'b1;
					result.kind            = shd_pkg::KIND_HEADER;
					result.send_node       = send_d;
					result.recv_node       = recv_d;
					result.app_id          = app_d;
					result.server_id       = srv_d;
					result.event_id        = evt_d;
					result.message_type    = msg_d;
					result.payload_length  = len_d;
					result.deliver_local   = local_hit;
					rem_d                  = len_d;
					result.frame_last      = (len_d == 32'd0);
					phase_d = (len_d == 32'd0) ? shd_pkg::PH_HUNT : shd_pkg::PH_PAY;
				end
			end
			shd_pkg::PH_PAY: begin
				has_result          = 1'b1;
				result.kind         = shd_pkg::KIND_PAYLOAD;
				result.payload_byte = byte_in;
				rem_d               = rem_dec;
				if (rem_dec == 32'd0) begin
					result.frame_last = 1'b1;
					phase_d           = shd_pkg::PH_HUNT;
				end
			end
			default: begin
				phase_d = shd_pkg::PH_HUNT;
			end
		endcase
	end

endmodule

/* rtl/sync_header_deframer_top.sv */
`timescale 1ns / 1ps

// Byte-stream deframer: hunts for the sync pair 0x03 0x16, collects the rest of
// a 28-byte big-endian header, emits one header result (kind 0, with the
// deliver_local flag from node_id / main_server_id), then one result per payload
// byte (kind 1); frame_last marks the final result of each frame. One byte is
// accepted per clock while in_stall is low; a byte moves through an input
// register and the parser into the result register, which presents its result.
// in_stall rises only while a byte sits in the input register and the result
// register is full and stalled. Write node_id and main_server_id only while idle.
module sync_header_deframer_top (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [31:0] send_node,
	output logic [31:0] recv_node,
	output logic [31:0] app_id,
	output logic [31:0] server_id,
	output logic [15:0] event_id,
	output logic [15:0] message_type,
	output logic [31:0] payload_length,
	output logic        deliver_local,
	output logic [7:0]  payload_byte,
	output logic        frame_last
);

	shd_pkg::cfg_t    cfg_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             out_valid_q;
	shd_pkg::result_t res_q;
	shd_pkg::result_t res;
	logic             has_result;
	logic             hold;
	logic             step;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				shd_pkg::CFG_NODE_ID:        cfg_q.node_id        <= cfg_data;
				shd_pkg::CFG_MAIN_SERVER_ID: cfg_q.main_server_id <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake control
	assign hold     = out_valid_q && out_stall;
	assign step     = valid_s1 && !hold;
	assign in_stall = valid_s1 && hold;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) byte_s1 <= data_byte;
	end

	shd_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.byte_in    (byte_s1),
		.cfg        (cfg_q),
		.has_result (has_result),
		.result     (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && has_result) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result) res_q <= res;
	end

	assign out_valid      = out_valid_q;
	assign kind           = res_q.kind;
	assign send_node      = res_q.send_node;
	assign recv_node      = res_q.recv_node;
	assign app_id         = res_q.app_id;
	assign server_id      = res_q.server_id;
	assign event_id       = res_q.event_id;
	assign message_type   = res_q.message_type;
	assign payload_length = res_q.payload_length;
	assign deliver_local  = res_q.deliver_local;
	assign payload_byte   = res_q.payload_byte;
	assign frame_last     = res_q.frame_last;

	// Checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_header_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == shd_pkg::KIND_HEADER)) |-> (payload_byte == 8'd0))
		else $error("header result carries a payload byte");

	a_payload_no_header: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == shd_pkg::KIND_PAYLOAD)) |->
		(!deliver_local && (payload_length == 32'd0) && (send_node == 32'd0)))
		else $error("payload result carries header fields");

	a_empty_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (kind == shd_pkg::KIND_HEADER) && (payload_length == 32'd0))
		|-> frame_last)
		else $error("empty frame header not marked last");

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import shd_pkg::*;

	localparam int HDR_LEN        = POS_LAST + 1;
	localparam int WATCHDOG_LIMIT = 1000;

	// Header word slots of the shadow deframer
	localparam int F_SEND   = 0;
	localparam int F_RECV   = 1;
	localparam int F_APP    = 2;
	localparam int F_SERVER = 3;
	localparam int F_EVENT  = 4;
	localparam int F_MSG    = 5;
	localparam int F_LEN    = 6;

	typedef enum logic [2:0] {
		OP_NOISE,
		OP_BAD_SYNC,
		OP_FRAME,
		OP_FRAME_DSYNC,
		OP_CFG
	} dir_op_e;

	// One directed row; loc is the typed deliver_local when pin is set
	typedef struct packed {
		dir_op_e     op;
		logic        reg_idx;
		logic [31:0] val;
		logic [31:0] sn;
		logic [31:0] rn;
		logic [31:0] app;
		logic [31:0] srv;
		logic [15:0] ev;
		logic [15:0] mt;
		logic [31:0] len;
		logic        pin;
		logic        loc;
	} dir_row_t;

	// One stream byte waiting to be sent
	typedef struct packed {
		logic [7:0] b;
		logic       pin;
		logic       loc;
	} tx_item_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data  = 32'h0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [31:0] send_node;
	logic [31:0] recv_node;
	logic [31:0] app_id;
	logic [31:0] server_id;
	logic [15:0] event_id;
	logic [15:0] message_type;
	logic [31:0] payload_length;
	logic        deliver_local;
	logic [7:0]  payload_byte;
	logic        frame_last;

	sync_header_deframer_top DUT (.*);

	initial begin
		forever #10 clk = ~clk;
	end

	// Shadow copy of the deframer and its registers
	phase_t      shadow_phase = PH_HUNT;
	logic [4:0]  shadow_count = '0;
	logic [31:0] shadow_fields [7];
	logic [31:0] shadow_left  = '0;
	logic [31:0] cfg_node     = '0;
	logic [31:0] cfg_main     = '0;

	tx_item_t tx_bytes [$];
	result_t  expected_results [$];

	int err_count    = 0;
	int bytes_queued = 0;
	int bytes_in     = 0;
	int results_out  = 0;
	int headers_out  = 0;
	int idle_cycles  = 0;
	int tx_gap       = 0;
	int tx_calm      = 0;
	int rx_left      = 0;
	int rx_calm      = 0;

	initial begin
		for (int i = 0; i < 7; i++) shadow_fields[i] = '0;
	end

	// Directed stimulus; typed deliver_local only where it is obvious
	dir_row_t dir_table [18] = '{
		'{OP_NOISE, 1'b0, 32'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0},
		'{OP_NOISE, 1'b0, 32'hFF, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0},
		'{OP_NOISE, 1'b0, 32'h16, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0},
		'{OP_BAD_SYNC, 1'b0, 32'h00, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0,
			1'b0, 1'b0},
		'{OP_BAD_SYNC, 1'b0, 32'hFF, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0,
			1'b0, 1'b0},
		// all-zero header right after reset, empty payload
		'{OP_FRAME, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1},
		'{OP_FRAME, 1'b0, 32'h0, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 32'h1, 1'b1, 1'b0},
		'{OP_FRAME_DSYNC, 1'b0, 32'h0, 32'h0, 32'h0, 32'h12345678, 32'h0, 16'h0, 16'h0,
			32'h3, 1'b1, 1'b1},
		'{OP_FRAME, 1'b0, 32'h0, 32'h5, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h2, 1'b1, 1'b1},
		'{OP_FRAME, 1'b0, 32'h0, 32'h0, 32'h0, 32'h7, 32'h0, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1},
		'{OP_CFG, CFG_NODE_ID, '1, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0},
		'{OP_CFG, CFG_MAIN_SERVER_ID, '1, 32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 32'h0,
			1'b0, 1'b0},
		'{OP_FRAME, 1'b0, 32'h0, '1, '1, 32'h0, '1, 16'hFFFF, 16'h0, 32'h1, 1'b1, 1'b1},
		'{OP_FRAME, 1'b0, 32'h0, 32'h0, 32'h0, 32'h0, '1, 16'h0, 16'h0, 32'h0, 1'b1, 1'b1},
		'{OP_FRAME, 1'b0, 32'h0, 32'h1, 32'h0, 32'h0, '1, 16'h0, 16'h0, 32'h0, 1'b1, 1'b0},
		'{OP_FRAME, 1'b0, 32'h0, 32'h0, 32'hFFFFFFFE, 32'h0, '1, 16'h0, 16'h0, 32'h2,
			1'b1, 1'b0},
		'{OP_FRAME, 1'b0, 32'h0, 32'h0, '1, 32'h0, 32'hFFFFFFFE, 16'h0, 16'h0, 32'h0,
			1'b1, 1'b0},
		'{OP_FRAME, 1'b0, 32'h0, 32'h89ABCDEF, 32'h01234567, 32'hDEADBEEF, 32'h76543210,
			16'hA5C3, 16'h5A3C, 32'h4, 1'b0, 1'b0}
	};

	// Shadow deframer: one stream byte in, at most one result out
	task automatic deframe_step(input logic [7:0] b, output bit got, output result_t r);
		logic [4:0] pos;
		int         s;
		got = 1'b0;
		r   = '0;
		case (shadow_phase)
			PH_HUNT: begin
				if (b == SYNC_FIRST) shadow_phase = PH_SYNC;
			end
			PH_SYNC: begin
				if (b == SYNC_SECOND) begin
					shadow_phase = PH_HEAD;
					shadow_count = POS_FIRST_FIELD;
					for (int i = 0; i < 7; i++) shadow_fields[i] = '0;
				end else if (b != SYNC_FIRST) begin
					shadow_phase = PH_HUNT;
				end
			end
			PH_HEAD: begin
				pos = shadow_count;
				if (pos >= POS_SEND) begin
					if (pos < POS_EVENT) s = int'(pos - POS_SEND) >> 2;
					else if (pos < POS_MSG) s = F_EVENT;
					else if (pos < POS_LEN) s = F_MSG;
					else s = F_LEN;
					shadow_fields[s] = {shadow_fields[s][23:0], b};
					if (s == F_EVENT || s == F_MSG) shadow_fields[s][31:16] = '0;
				end
				if (pos != POS_LAST) begin
					shadow_count = pos + 5'd1;
				end else begin
					got              = 1'b1;
					r.kind           = KIND_HEADER;
					r.send_node      = shadow_fields[F_SEND];
					r.recv_node      = shadow_fields[F_RECV];
					r.app_id         = shadow_fields[F_APP];
					r.server_id      = shadow_fields[F_SERVER];
					r.event_id       = shadow_fields[F_EVENT][15:0];
					r.message_type   = shadow_fields[F_MSG][15:0];
					r.payload_length = shadow_fields[F_LEN];
					// local when the main server matches and the frame is ours or unaddressed
					r.deliver_local = (r.server_id == cfg_main) &&
						((r.recv_node == '0 && r.send_node == '0) || r.recv_node == cfg_node);
					shadow_left  = shadow_fields[F_LEN];
					shadow_count = '0;
					if (shadow_left == '0) begin
						r.frame_last = 1'b1;
						shadow_phase = PH_HUNT;
					end else begin
						shadow_phase = PH_PAY;
					end
				end
			end
			default: begin
				got            = 1'b1;
				r.kind         = KIND_PAYLOAD;
				r.payload_byte = b;
				if (shadow_left != '0) shadow_left = shadow_left - 32'd1;
				if (shadow_left == '0) begin
					r.frame_last = 1'b1;
					shadow_phase = PH_HUNT;
				end
			end
		endcase
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic pin, input logic loc);
		tx_item_t t;
		t.b   = b;
		t.pin = pin;
		t.loc = loc;
		tx_bytes.push_back(t);
		bytes_queued++;
	endtask

	// Queue one frame: optional extra sync byte, sync pair, big-endian header, npay payload bytes
	task automatic push_frame(input result_t h, input int npay, input bit dsync,
			input bit pay_sync, input logic pin, input logic loc);
		logic [7:0] hb [HDR_LEN];
		hb[0] = SYNC_FIRST;
		hb[1] = SYNC_SECOND;
		hb[2] = 8'($urandom);
		hb[3] = 8'($urandom);
		for (int i = 0; i < 4; i++) begin
			hb[POS_SEND + i]   = h.send_node[31 - 8 * i -: 8];
			hb[POS_RECV + i]   = h.recv_node[31 - 8 * i -: 8];
			hb[POS_APP + i]    = h.app_id[31 - 8 * i -: 8];
			hb[POS_SERVER + i] = h.server_id[31 - 8 * i -: 8];
			hb[POS_LEN + i]    = h.payload_length[31 - 8 * i -: 8];
		end
		for (int i = 0; i < 2; i++) begin
			hb[POS_EVENT + i] = h.event_id[15 - 8 * i -: 8];
			hb[POS_MSG + i]   = h.message_type[15 - 8 * i -: 8];
		end
		if (dsync) push_byte(SYNC_FIRST, 1'b0, 1'b0);
		for (int i = 0; i < HDR_LEN; i++) push_byte(hb[i], pin && (i == POS_LAST), loc);
		// directed payloads carry sync bytes that must pass through untouched
		for (int i = 0; i < npay; i++) begin
			if (pay_sync) push_byte((i % 2 == 0) ? SYNC_FIRST : SYNC_SECOND, 1'b0, 1'b0);
			else push_byte(8'($urandom), 1'b0, 1'b0);
		end
	endtask

	task automatic wait_drained();
		while (tx_bytes.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NODE_ID) cfg_node = val;
		else cfg_main = val;
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			err_count++;
		end
	endtask

	// Sender: predicts each accepted transaction, then drives the next byte
	always @(posedge clk) begin : sender
		bit       got;
		result_t  r;
		logic     nv;
		logic [7:0] nd;
		nv = in_valid;
		nd = data_byte;
		if (in_valid && !in_stall) begin
			deframe_step(tx_bytes[0].b, got, r);
			if (got) begin
				if (tx_bytes[0].pin) r.deliver_local = tx_bytes[0].loc;
				expected_results.push_back(r);
			end
			void'(tx_bytes.pop_front());
			bytes_in++;
			nv = 1'b0;
			if (tx_calm > 0) begin
				tx_calm--;
				tx_gap = 0;
			end else begin
				if ($urandom_range(0, 49) == 0) tx_calm = $urandom_range(20, 80);
				tx_gap = gap_len();
			end
		end
		if (!nv && arst_n) begin
			if (tx_gap > 0) tx_gap--;
			else if (tx_bytes.size() > 0) begin
				nv = 1'b1;
				nd = tx_bytes[0].b;
			end
		end
		in_valid  <= nv;
		data_byte <= nd;
	end

	// Receiver stall pattern
	always @(posedge clk) begin : receiver
		int n;
		if (rx_left > 0) begin
			rx_left--;
			out_stall <= 1'b1;
		end else if (rx_calm > 0) begin
			rx_calm--;
			out_stall <= 1'b0;
		end else begin
			if ($urandom_range(0, 49) == 0) rx_calm = $urandom_range(20, 80);
			n = gap_len();
			out_stall <= (n > 0);
			rx_left = (n > 0) ? n - 1 : 0;
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : monitor
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_out++;
			if (kind == KIND_HEADER) headers_out++;
			if (expected_results.size() == 0) begin
				$error("result with no transaction pending, kind %0d", kind);
				err_count++;
			end else begin
				want = expected_results.pop_front();
				check_field("kind", 32'(want.kind), 32'(kind));
				check_field("send_node", want.send_node, send_node);
				check_field("recv_node", want.recv_node, recv_node);
				check_field("app_id", want.app_id, app_id);
				check_field("server_id", want.server_id, server_id);
				check_field("event_id", 32'(want.event_id), 32'(event_id));
				check_field("message_type", 32'(want.message_type), 32'(message_type));
				check_field("payload_length", want.payload_length, payload_length);
				check_field("deliver_local", 32'(want.deliver_local), 32'(deliver_local));
				check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte));
				check_field("frame_last", 32'(want.frame_last), 32'(frame_last));
			end
		end
	end

	// Cycles with no transaction on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
	end

	initial begin : watchdog
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("tb: failure");
		$finish;
	end

	initial begin : main
		dir_row_t   row;
		result_t    h;
		int         budget;
		int         pick;
		int         n;
		logic [7:0] b;
		bit         paused;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int k = 0; k < $size(dir_table); k++) begin
			row = dir_table[k];
			case (row.op)
				OP_NOISE: push_byte(row.val[7:0], 1'b0, 1'b0);
				OP_BAD_SYNC: begin
					push_byte(SYNC_FIRST, 1'b0, 1'b0);
					push_byte(row.val[7:0], 1'b0, 1'b0);
				end
				OP_CFG: begin
					wait_drained();
					write_reg(row.reg_idx, row.val);
				end
				default: begin
					h                = '0;
					h.send_node      = row.sn;
					h.recv_node      = row.rn;
					h.app_id         = row.app;
					h.server_id      = row.srv;
					h.event_id       = row.ev;
					h.message_type   = row.mt;
					h.payload_length = row.len;
					push_frame(h, int'(row.len), row.op == OP_FRAME_DSYNC, 1'b1, row.pin,
						row.loc);
				end
			endcase
		end

		// Random phases, one register setting each
		for (int p = 0; p < 4; p++) begin
			wait_drained();
			case (p)
				1: begin
					write_reg(CFG_NODE_ID, '0);
					write_reg(CFG_MAIN_SERVER_ID, '1);
				end
				2: begin
					write_reg(CFG_NODE_ID, '1);
					write_reg(CFG_MAIN_SERVER_ID, '0);
				end
				default: begin
					write_reg(CFG_NODE_ID, $urandom);
					write_reg(CFG_MAIN_SERVER_ID, $urandom);
				end
			endcase
			budget = bytes_queued + 35;
			while (bytes_queued < budget) begin
				// one full drain in the middle of a phase
				if (p == 1 && !paused && bytes_queued >= budget - 30) begin
					paused = 1'b1;
					wait_drained();
				end
				pick = $urandom_range(0, 99);
				if (pick < 80) begin
					h = '0;
					h.server_id = ($urandom_range(0, 1) == 1) ? cfg_main : pick_word();
					pick = $urandom_range(0, 9);
					h.recv_node = (pick < 3) ? cfg_node : (pick < 5) ? 32'h0 : pick_word();
					h.send_node = ($urandom_range(0, 2) == 0) ? 32'h0 : pick_word();
					h.app_id = pick_word();
					h.event_id = 16'(pick_word());
					h.message_type = ($urandom_range(0, 3) == 0) ? 16'h0 : 16'(pick_word());
					pick = $urandom_range(0, 99);
					h.payload_length = (pick < 85) ? $urandom_range(0, 6) : $urandom_range(7, 40);
					push_frame(h, int'(h.payload_length), $urandom_range(0, 9) == 0, 1'b0,
						1'b0, 1'b0);
				end else if (pick < 90) begin
					// noise while hunting
					n = $urandom_range(1, 6);
					repeat (n) begin
						do b = 8'($urandom); while (b == SYNC_FIRST);
						push_byte(b, 1'b0, 1'b0);
					end
				end else begin
					// first sync byte followed by a wrong one
					push_byte(SYNC_FIRST, 1'b0, 1'b0);
					do b = 8'($urandom); while (b == SYNC_FIRST || b == SYNC_SECOND);
					push_byte(b, 1'b0, 1'b0);
				end
			end
		end

		// Longest length last: the payload never ends, so nothing follows it
		h = '1;
		push_frame(h, 20, 1'b0, 1'b0, 1'b0, 1'b0);

		wait_drained();
		repeat (4) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			err_count++;
		end
		$display("summary: %0d stream bytes sent, %0d results checked (%0d headers)",
			bytes_in, results_out, headers_out);
		$display("summary: directed table plus four random register settings, %0d errors",
			err_count);
		if (err_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end

endmodule

/* sync_header_deframer_top.f */
rtl/shd_pkg.sv
rtl/shd_parser.sv
rtl/sync_header_deframer_top.sv
bench/testbench.sv
